FILE: hw/rtl/lnps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnps_pkg
// Shared types, constants and the control store of the last-note-priority
// stack: step codes, jump conditions, control word layout and its program.
// ----------------------------------------------------------------------------
package lnps_pkg;

  localparam int NOTE_W = 7;
  localparam logic [7:0] NO_NOTE = 8'd128;

  typedef enum logic [2:0] {
    STEP_FETCH    = 3'd0,
    STEP_LATCH    = 3'd1,
    STEP_P_UNLINK = 3'd2,
    STEP_P_LINK   = 3'd3,
    STEP_R_CHECK  = 3'd4,
    STEP_R_DROP   = 3'd5,
    STEP_RD_TOP   = 3'd6,
    STEP_EMIT     = 3'd7
  } step_t;

  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_BAD_CH   = 3'd2,
    COND_OFF      = 3'd3,
    COND_IS_TOP   = 3'd4,
    COND_NOT_HELD = 3'd5
  } cond_t;

  typedef struct packed {
    logic  rd_row;    // read note row, capture channel top
    logic  rd_top;    // read velocity of the current top
    logic  latch;     // capture row read data
    logic  unlink;    // join neighbors of the note (when linked)
    logic  vel_new;   // store request velocity
    logic  vel_drop;  // mark note not held
    logic  link_top;  // push note on top of the channel list
    logic  drop_top;  // fall back to the note below (when note is top)
    logic  emit;      // present result, end of program
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic bad_ch;
    logic is_off;
    logic is_top;
    logic not_held;
  } flags_t;

  typedef struct packed {
    logic vel;
    logic prv;
    logic nxt;
  } mem_we_t;

  typedef struct packed {
    logic [7:0] vel;
    logic [7:0] prv;
    logic [7:0] nxt;
  } rd_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = uword_t'('0);
    unique case (s)
      STEP_FETCH: begin
        w.rd_row = 1'b1;
        w.cond   = COND_BAD_CH;
        w.target = STEP_RD_TOP;
      end
      STEP_LATCH: begin
        w.latch  = 1'b1;
        w.cond   = COND_OFF;
        w.target = STEP_R_CHECK;
      end
      STEP_P_UNLINK: begin
        w.unlink  = 1'b1;
        w.vel_new = 1'b1;
        w.cond    = COND_IS_TOP;
        w.target  = STEP_RD_TOP;
      end
      STEP_P_LINK: begin
        w.link_top = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = STEP_RD_TOP;
      end
      STEP_R_CHECK: begin
        w.cond   = COND_NOT_HELD;
        w.target = STEP_RD_TOP;
      end
      STEP_R_DROP: begin
        w.vel_drop = 1'b1;
        w.unlink   = 1'b1;
        w.drop_top = 1'b1;
      end
      STEP_RD_TOP: begin
        w.rd_top = 1'b1;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/last_note_priority_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// last_note_priority_stack
// Per-channel last-note-priority mono voice: a linked note list per channel,
// updated by a microcoded sequencer over link memories with one read and one write port.
// ----------------------------------------------------------------------------
// steps: an ignored channel goes from fetch straight to reading the top; note on
//   and note off also latch the note row and update the links first
// busy falls with done, so the next request can be taken in the cycle the result
//   is shown; no new request is taken while busy
// reset: a clearing pass over every row of the link memories follows reset,
//   busy stays high during it
// ----------------------------------------------------------------------------
module last_note_priority_stack #(
  parameter int CHANNELS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       req_type,
  input  logic [6:0] note_number,
  input  logic [6:0] note_velocity,
  input  logic [3:0] midi_channel,
  output logic       done,
  output logic [7:0] current_note,
  output logic [7:0] current_velocity,
  output logic       note_active
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W = CH_W + lnps_pkg::NOTE_W;
  localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

  lnps_pkg::uword_t  uw;
  lnps_pkg::flags_t  flags;
  lnps_pkg::mem_we_t we;
  lnps_pkg::rd_t     rd;
  logic running;
  logic clearing;
  logic go;

  logic              kind_q;
  logic [6:0]        note_q;
  logic [6:0]        vel_q;
  logic [CH_W-1:0]   ch_q;
  logic              ch_ok;
  logic [7:0]        top;
  logic [7:0]        heldv;
  logic [7:0]        lnk_below;
  logic [7:0]        lnk_above;
  logic [7:0]        top_note [CHANNELS];
  logic [7:0]        top_sel;
  logic              linked;
  logic              unlink_go;
  logic [ADDR_W-1:0] row_n;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] vel_waddr, prv_waddr, nxt_waddr;
  logic [7:0]        vel_wdata, prv_wdata, nxt_wdata;

  assign busy = running | clearing;
  assign go   = start & ~busy;

  lnps_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .flags   (flags),
    .uw      (uw),
    .running (running)
  );

  lnps_link_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .we        (we),
    .vel_waddr (vel_waddr),
    .vel_wdata (vel_wdata),
    .prv_waddr (prv_waddr),
    .prv_wdata (prv_wdata),
    .nxt_waddr (nxt_waddr),
    .nxt_wdata (nxt_wdata),
    .rd        (rd),
    .clearing  (clearing)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (go) begin
      kind_q <= req_type;
      note_q <= note_number;
      vel_q  <= note_velocity;
      ch_q   <= midi_channel[CH_W-1:0];
      ch_ok  <= ({1'b0, midi_channel} < CH_LIMIT);
    end
  end

  assign top_sel   = ch_ok ? top_note[ch_q] : lnps_pkg::NO_NOTE;
  assign row_n     = {ch_q, note_q};
  assign linked    = (heldv != lnps_pkg::NO_NOTE) && ({1'b0, note_q} != top);
  assign unlink_go = uw.unlink & linked;

  assign flags.bad_ch   = ~ch_ok;
  assign flags.is_off   = kind_q;
  assign flags.is_top   = ({1'b0, note_q} == top);
  assign flags.not_held = (heldv == lnps_pkg::NO_NOTE);

  always_ff @(posedge clk) begin
    if (uw.rd_row) begin
      top <= top_sel;
    end else if (uw.link_top) begin
      top <= {1'b0, note_q};
    end else if (uw.drop_top && flags.is_top) begin
      top <= lnk_below;
    end
    if (uw.latch) begin
      heldv     <= rd.vel;
      lnk_below <= rd.prv;
      lnk_above <= rd.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        top_note[i] <= lnps_pkg::NO_NOTE;
      end
    end else if (uw.link_top) begin
      top_note[ch_q] <= {1'b0, note_q};
    end else if (uw.drop_top && flags.is_top) begin
      top_note[ch_q] <= lnk_below;
    end
  end

  // memory ports; sentinel links are never read, so writes to them are dropped
  assign rd_addr = uw.rd_top ? {ch_q, top[6:0]} : row_n;

  assign we.vel    = uw.vel_new | uw.vel_drop;
  assign vel_waddr = row_n;
  assign vel_wdata = uw.vel_drop ? lnps_pkg::NO_NOTE : {1'b0, vel_q};

  assign we.nxt    = (unlink_go && (lnk_below != lnps_pkg::NO_NOTE))
                   || (uw.link_top && (top != lnps_pkg::NO_NOTE));
  assign nxt_waddr = uw.link_top ? {ch_q, top[6:0]} : {ch_q, lnk_below[6:0]};
  assign nxt_wdata = uw.link_top ? {1'b0, note_q} : lnk_above;

  assign we.prv    = (unlink_go && (lnk_above != lnps_pkg::NO_NOTE)) || uw.link_top;
  assign prv_waddr = uw.link_top ? row_n : {ch_q, lnk_above[6:0]};
  assign prv_wdata = uw.link_top ? top : lnk_below;

  // result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= uw.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.emit) begin
      current_note <= top;
      if (top == lnps_pkg::NO_NOTE) begin
        current_velocity <= lnps_pkg::NO_NOTE;
        note_active      <= 1'b0;
      end else begin
        current_velocity <= rd.vel;
        note_active      <= 1'b1;
      end
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_busy_after_go: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a request");

  a_active_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (note_active == (current_note != lnps_pkg::NO_NOTE)))
    else $error("note_active disagrees with current_note");

  a_active_velocity: assert property (@(posedge clk) disable iff (rst)
    (done && note_active) |-> !current_velocity[7])
    else $error("held note reports an out of range velocity");

endmodule

FILE: hw/rtl/lnps_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnps_seq
// Step counter over the control store, with conditional jumps taken from
// datapath flags. Starts at the fetch step on each request.
// ----------------------------------------------------------------------------
module lnps_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  lnps_pkg::flags_t  flags,
  output lnps_pkg::uword_t  uw,
  output logic              running
);

  lnps_pkg::step_t step, step_next;
  logic running_next;
  logic take;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= lnps_pkg::STEP_FETCH;
    end else begin
      running <= running_next;
      step    <= step_next;
    end
  end

  always_comb begin
    unique case (uw.cond)
      lnps_pkg::COND_NEXT:     take = 1'b0;
      lnps_pkg::COND_ALWAYS:   take = 1'b1;
      lnps_pkg::COND_BAD_CH:   take = flags.bad_ch;
      lnps_pkg::COND_OFF:      take = flags.is_off;
      lnps_pkg::COND_IS_TOP:   take = flags.is_top;
      lnps_pkg::COND_NOT_HELD: take = flags.not_held;
      default:                 take = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    step_next    = step;
    running_next = running;
    if (go) begin
      step_next    = lnps_pkg::STEP_FETCH;
      running_next = 1'b1;
    end else if (running) begin
      if (uw.emit) begin
        running_next = 1'b0;
      end else if (take) begin
        step_next = uw.target;
      end else begin
        step_next = lnps_pkg::step_t'(step + 3'd1);
      end
    end
  end

  // control word
  always_comb begin
    if (running) begin
      uw = lnps_pkg::ucode(step);
    end else begin
      uw = lnps_pkg::uword_t'('0);
    end
  end

endmodule

FILE: hw/rtl/lnps_link_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnps_link_store
// Velocity, lower-link and upper-link memories, one row per channel and note.
// A clearing pass after reset sets every row to no note.
// ----------------------------------------------------------------------------
module lnps_link_store #(
  parameter int ADDR_W = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [ADDR_W-1:0]  rd_addr,
  input  lnps_pkg::mem_we_t  we,
  input  logic [ADDR_W-1:0]  vel_waddr,
  input  logic [7:0]         vel_wdata,
  input  logic [ADDR_W-1:0]  prv_waddr,
  input  logic [7:0]         prv_wdata,
  input  logic [ADDR_W-1:0]  nxt_waddr,
  input  logic [7:0]         nxt_wdata,
  output lnps_pkg::rd_t      rd,
  output logic               clearing
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [7:0] vel_mem [DEPTH];
  logic [7:0] prv_mem [DEPTH];
  logic [7:0] nxt_mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      vel_mem[clr_addr] <= lnps_pkg::NO_NOTE;
    end else if (we.vel) begin
      vel_mem[vel_waddr] <= vel_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      prv_mem[clr_addr] <= lnps_pkg::NO_NOTE;
    end else if (we.prv) begin
      prv_mem[prv_waddr] <= prv_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      nxt_mem[clr_addr] <= lnps_pkg::NO_NOTE;
    end else if (we.nxt) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd.vel <= vel_mem[rd_addr];
    rd.prv <= prv_mem[rd_addr];
    rd.nxt <= nxt_mem[rd_addr];
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the last-note-priority stack: a directed opening
// and about 1100 random note-on/note-off requests with random gaps, checked
// against a local model of the per-channel linked note lists.
// ----------------------------------------------------------------------------
module tb;

  localparam int CH_COUNT    = 16;
  localparam int SLOT_COUNT  = 129;
  localparam int RAND_EVENTS = 1100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 12;

  typedef enum bit {NOTE_ON = 1'b0, NOTE_OFF = 1'b1} note_kind_t;

  typedef struct {
    note_kind_t kind;
    bit [6:0]   note;
    bit [6:0]   vel;
    bit [3:0]   ch;
    int         gap;
    bit         drain;
  } note_event_t;

  typedef struct {
    logic [7:0] note;
    logic [7:0] vel;
    logic       active;
  } voice_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       req_type = 1'b0;
  logic [6:0] note_number = '0;
  logic [6:0] note_velocity = '0;
  logic [3:0] midi_channel = '0;
  logic       busy, done, note_active;
  logic [7:0] current_note, current_velocity;

  last_note_priority_stack #(.CHANNELS(CH_COUNT)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .note_number(note_number),
    .note_velocity(note_velocity), .midi_channel(midi_channel),
    .done(done), .current_note(current_note),
    .current_velocity(current_velocity), .note_active(note_active)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // local copy of the note lists
  logic [7:0] link_older [CH_COUNT][SLOT_COUNT];
  logic [7:0] link_newer [CH_COUNT][SLOT_COUNT];
  logic [7:0] slot_vel   [CH_COUNT][SLOT_COUNT];
  logic [7:0] chan_top   [CH_COUNT];

  note_event_t pending_events[$];
  voice_t      voice_expect[$];
  note_event_t nxt;
  bit          have_nxt = 1'b0;
  bit          req_taken = 1'b0;
  bit          calm = 1'b0;
  int          cycle_count = 0;
  int          mismatches = 0;
  int          checked = 0;
  int          on_count = 0;
  int          off_count = 0;
  bit [15:0]   chans_seen = '0;

  function automatic void detach_note(int ch, int n);
    int older, newer;
    older = link_older[ch][n];
    newer = link_newer[ch][n];
    link_newer[ch][older] = newer[7:0];
    link_older[ch][newer] = older[7:0];
  endfunction

  function automatic voice_t predict_voice(note_kind_t kind, int n, int vel, int ch);
    voice_t v;
    int     top;
    v.note   = lnps_pkg::NO_NOTE;
    v.vel    = lnps_pkg::NO_NOTE;
    v.active = 1'b0;
    if (ch >= CH_COUNT) return v;
    top = chan_top[ch];
    if (kind == NOTE_ON) begin
      if (slot_vel[ch][n] != lnps_pkg::NO_NOTE && n != top) detach_note(ch, n);
      slot_vel[ch][n] = vel[7:0];
      if (n != top) begin
        link_newer[ch][top] = n[7:0];
        link_older[ch][n]   = top[7:0];
        chan_top[ch]        = n[7:0];
      end
    end else if (slot_vel[ch][n] != lnps_pkg::NO_NOTE) begin
      slot_vel[ch][n] = lnps_pkg::NO_NOTE;
      if (n == top) chan_top[ch] = link_older[ch][n];
      else detach_note(ch, n);
    end
    top = chan_top[ch];
    if (top != lnps_pkg::NO_NOTE) begin
      v.note   = top[7:0];
      v.vel    = slot_vel[ch][top];
      v.active = 1'b1;
    end
    return v;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_event(note_kind_t kind, int n, int vel, int ch, bit drain = 1'b0);
    note_event_t e;
    e.kind  = kind;
    e.note  = n[6:0];
    e.vel   = vel[6:0];
    e.ch    = ch[3:0];
    e.gap   = draw_gap();
    e.drain = drain;
    pending_events.push_back(e);
  endtask

  // driver: inputs move on the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !req_taken) begin
        // request still waiting for the block
      end else begin
        if (!have_nxt && pending_events.size() > 0) begin
          nxt = pending_events.pop_front();
          have_nxt = 1'b1;
        end
        if (have_nxt && nxt.gap > 0) begin
          nxt.gap = nxt.gap - 1;
          start <= 1'b0;
        end else if (have_nxt && !(nxt.drain && voice_expect.size() > 0)) begin
          req_type      <= nxt.kind;
          note_number   <= nxt.note;
          note_velocity <= nxt.vel;
          midi_channel  <= nxt.ch;
          start         <= 1'b1;
          have_nxt = 1'b0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: requests and results sampled on the rising edge
  always @(posedge clk) begin
    voice_t got, want;
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end else if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      if (done) begin
        got.note   = current_note;
        got.vel    = current_velocity;
        got.active = note_active;
        if (voice_expect.size() == 0) begin
          $error("result with nothing expected: note %0d vel %0d active %0d",
                 got.note, got.vel, got.active);
          mismatches++;
        end else begin
          want = voice_expect.pop_front();
          checked++;
          if (got.note !== want.note) begin
            $error("current_note: expected %0d, got %0d", want.note, got.note);
            mismatches++;
          end
          if (got.vel !== want.vel) begin
            $error("current_velocity: expected %0d, got %0d", want.vel, got.vel);
            mismatches++;
          end
          if (got.active !== want.active) begin
            $error("note_active: expected %0d, got %0d", want.active, got.active);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        voice_expect.push_back(predict_voice(note_kind_t'(req_type), note_number,
                                             note_velocity, midi_channel));
        if (req_type == NOTE_ON) on_count++;
        else off_count++;
        chans_seen[midi_channel] = 1'b1;
      end
    end
  end

  initial begin
    int ch, n, r;
    for (int c = 0; c < CH_COUNT; c++) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        link_older[c][s] = lnps_pkg::NO_NOTE;
        link_newer[c][s] = lnps_pkg::NO_NOTE;
        slot_vel[c][s]   = lnps_pkg::NO_NOTE;
      end
      chan_top[c] = lnps_pkg::NO_NOTE;
    end

    // directed opening
    calm = 1'b1;
    add_event(NOTE_ON, 60, 100, 0);
    add_event(NOTE_ON, 64, 0, 0);       // velocity zero still holds the note
    add_event(NOTE_ON, 67, 127, 0);
    add_event(NOTE_ON, 67, 50, 0);      // top note again: velocity update only
    add_event(NOTE_ON, 60, 10, 0);      // held below top: moves to top
    add_event(NOTE_OFF, 64, 0, 0);      // release from the bottom
    add_event(NOTE_OFF, 60, 0, 0);      // release top, falls back to 67
    add_event(NOTE_OFF, 99, 0, 0);      // not held
    add_event(NOTE_OFF, 67, 0, 0);
    add_event(NOTE_OFF, 67, 127, 0);    // empty channel, not held
    calm = 1'b0;
    add_event(NOTE_ON, 127, 127, 15);
    add_event(NOTE_ON, 0, 1, 15);
    add_event(NOTE_OFF, 127, 0, 15);    // release bottom under the top
    add_event(NOTE_OFF, 0, 0, 15);
    add_event(NOTE_ON, 0, 127, 5);
    add_event(NOTE_ON, 127, 0, 10);
    add_event(NOTE_ON, 42, 85, 5, 1'b1);
    add_event(NOTE_OFF, 0, 0, 5);
    add_event(NOTE_OFF, 127, 0, 10);
    add_event(NOTE_OFF, 42, 0, 5);

    // random part: note pools per channel keep lists deep, some noise on top
    for (int i = 0; i < RAND_EVENTS; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      ch = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15);
      r = $urandom_range(0, 99);
      if (r < 5) begin
        add_event(note_kind_t'($urandom_range(0, 1)), $urandom_range(0, 127),
                  $urandom_range(0, 127), ch, (i % 200 == 199));
      end else begin
        n = (ch * 8 + $urandom_range(0, 7)) % 128;
        add_event((r < 58) ? NOTE_ON : NOTE_OFF, n, $urandom_range(0, 127), ch,
                  (i % 200 == 199));
      end
    end

    repeat (6) @(negedge clk);
    rst = 1'b0;

    while (pending_events.size() != 0 || have_nxt || start || voice_expect.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d note-on and %0d note-off requests on %0d channels,",
             on_count, off_count, $countones(chans_seen));
    $display("%0d results compared, %0d field errors", checked, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
